[rtl/core/upe_pkg.sv]
// Shared types, constants and character functions of the URL percent escaper.
package upe_pkg;

    localparam logic [7:0] CHAR_PERCENT = 8'h25;
    localparam logic [7:0] HEX_DIGIT_BASE = 8'h30;
    localparam logic [7:0] HEX_ALPHA_BASE = 8'h37;
    localparam logic [3:0] HEX_ALPHA_START = 4'd10;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_EMIT
    } ctrl_state_t;

    typedef enum logic [1:0] {
        PH_FRESH,
        PH_HI,
        PH_LO
    } hex_phase_t;

    typedef struct packed {
        logic hold;
        logic run;
        logic step;
    } upe_cmd_t;

    typedef struct packed {
        logic seq_open;
        logic completes;
        logic in_lead;
        logic out_free;
        logic finish;
    } upe_status_t;

    function automatic logic [2:0] seq_len_of(input logic [7:0] b);
        logic [2:0] len;
        if ((b & 8'hF8) == 8'hF0) begin
            len = 3'd4;
        end else if ((b & 8'hF0) == 8'hE0) begin
            len = 3'd3;
        end else if ((b & 8'hE0) == 8'hC0) begin
            len = 3'd2;
        end else begin
            len = 3'd1;
        end
        return len;
    endfunction

    function automatic logic is_plain(input logic [7:0] b);
        return b inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A],
                         8'h5F, 8'h2D, 8'h2E};
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] c;
        if (nib < HEX_ALPHA_START) begin
            c = HEX_DIGIT_BASE + {4'h0, nib};
        end else begin
            c = HEX_ALPHA_BASE + {4'h0, nib};
        end
        return c;
    endfunction

endpackage

[rtl/core/upe_ctrl.sv]
// Controller state machine: decides hold or run per byte and paces emission.
module upe_ctrl import upe_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tlast,
    output logic        s_tready,
    input  upe_status_t st,
    output upe_cmd_t    cmd
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;
    logic        run_now;

    assign run_now = st.completes || s_tlast || !(st.seq_open || st.in_lead);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    if (run_now) begin
                        cmd.run    = 1'b1;
                        state_next = ST_EMIT;
                    end else begin
                        cmd.hold = 1'b1;
                    end
                end
            end
            ST_EMIT: begin
                if (st.out_free) begin
                    cmd.step = 1'b1;
                    if (st.finish) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

[rtl/core/upe_dpath.sv]
// Datapath: held UTF-8 bytes, classification walk and output register.
module upe_dpath import upe_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic [7:0]  s_tdata,
    input  logic        s_tlast,
    input  upe_cmd_t    cmd,
    output upe_status_t st,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,
    output logic        m_tlast
);

    logic [7:0] held_reg [4];
    logic [1:0] cnt_reg, cnt_next;
    logic [2:0] len_reg, len_next;
    logic [2:0] pos_reg, pos_next;
    logic [1:0] raw_left_reg, raw_left_next;
    hex_phase_t phase_reg, phase_next;
    logic       last_reg, last_next;
    logic [7:0] out_data_reg, out_data_next;
    logic       out_last_reg, out_last_next;
    logic       out_valid_reg, out_valid_next;

    logic [7:0] cur;
    logic [2:0] cur_cl;
    logic [2:0] raw_run;
    logic       fits;
    logic [7:0] step_char;
    logic [2:0] step_pos;
    logic [1:0] step_raw_left;
    hex_phase_t step_phase;
    logic       step_finish;

    assign cur     = held_reg[pos_reg[1:0]];
    assign cur_cl  = seq_len_of(cur);
    assign raw_run = cur_cl - 3'd1;
    assign fits    = ({1'b0, pos_reg} + {1'b0, cur_cl}) <= {1'b0, len_reg};

    always_comb begin
        step_char     = cur;
        step_pos      = pos_reg;
        step_raw_left = raw_left_reg;
        step_phase    = phase_reg;
        case (phase_reg)
            PH_HI: begin
                step_char  = hex_char(cur[7:4]);
                step_phase = PH_LO;
            end
            PH_LO: begin
                step_char  = hex_char(cur[3:0]);
                step_phase = PH_FRESH;
                step_pos   = pos_reg + 3'd1;
            end
            default: begin
                if (raw_left_reg != 2'd0) begin
                    step_raw_left = raw_left_reg - 2'd1;
                    step_pos      = pos_reg + 3'd1;
                end else if (cur_cl != 3'd1 && fits) begin
                    step_raw_left = raw_run[1:0];
                    step_pos      = pos_reg + 3'd1;
                end else if (is_plain(cur)) begin
                    step_pos = pos_reg + 3'd1;
                end else begin
                    step_char  = CHAR_PERCENT;
                    step_phase = PH_HI;
                end
            end
        endcase
        step_finish = (step_phase == PH_FRESH) && (step_pos == len_reg);
    end

    always_comb begin
        st.seq_open  = cnt_reg != 2'd0;
        st.completes = st.seq_open &&
                       ({1'b0, cnt_reg} + 3'd1 >= seq_len_of(held_reg[0]));
        st.in_lead   = seq_len_of(s_tdata) != 3'd1;
        st.out_free  = !out_valid_reg || m_tready;
        st.finish    = step_finish;
    end

    always_comb begin
        cnt_next       = cnt_reg;
        len_next       = len_reg;
        pos_next       = pos_reg;
        raw_left_next  = raw_left_reg;
        phase_next     = phase_reg;
        last_next      = last_reg;
        out_data_next  = out_data_reg;
        out_last_next  = out_last_reg;
        out_valid_next = out_valid_reg && !m_tready;
        if (cmd.hold) begin
            cnt_next = cnt_reg + 2'd1;
        end
        if (cmd.run) begin
            cnt_next      = 2'd0;
            len_next      = {1'b0, cnt_reg} + 3'd1;
            pos_next      = 3'd0;
            raw_left_next = 2'd0;
            phase_next    = PH_FRESH;
            last_next     = s_tlast;
        end
        if (cmd.step) begin
            pos_next       = step_pos;
            raw_left_next  = step_raw_left;
            phase_next     = step_phase;
            out_data_next  = step_char;
            out_last_next  = last_reg && step_finish;
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.hold || cmd.run) begin
            held_reg[cnt_reg] <= s_tdata;
        end
        len_reg      <= len_next;
        pos_reg      <= pos_next;
        raw_left_reg <= raw_left_next;
        phase_reg    <= phase_next;
        last_reg     <= last_next;
        out_data_reg <= out_data_next;
        out_last_reg <= out_last_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg       <= 2'd0;
            out_valid_reg <= 1'b0;
        end else begin
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

endmodule

[rtl/core/url_percent_escape_utf8.sv]
// URL percent escaper for a byte stream that passes complete UTF-8 sequences raw.
// The block produces one output character per cycle through a single output
// register while the output is not stalled: one for a plain byte, three for an
// escaped byte, and none for a byte held as part of an open UTF-8 sequence (the
// completing byte then yields every byte of the sequence). Input is not taken
// while characters of the previous item are still being produced; a stalled
// output holds the walk. tlast on the input marks the end of a string and
// flushes held bytes; tlast on the output marks its final character.
module url_percent_escape_utf8 import upe_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] in_byte
    input  logic       s_tlast,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic       m_tlast
);

    upe_cmd_t    cmd;
    upe_status_t st;

    upe_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .st       (st),
        .cmd      (cmd)
    );

    upe_dpath u_dpath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .cmd      (cmd),
        .st       (st),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

[rtl/core/upe_checker.sv]
// Port-level checks of the URL percent escaper and their binding to the top level.
module upe_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic [7:0] s_tdata,
    input logic       s_tlast,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tlast
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
        else $error("output transfer changed while stalled");

    a_reset_state: assert property (@(posedge aclk)
        !aresetn |=> (!m_tvalid && s_tready))
        else $error("block not idle after reset");

    a_last_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tlast) |=> !s_tready)
        else $error("final byte of a string produced no output");

    a_last_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tlast && s_tdata == 8'h25) |=> !s_tready)
        else $error("escaped final byte did not start output");

endmodule

bind url_percent_escape_utf8 upe_checker u_upe_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

[verif/tb_url_percent_escape_utf8.sv]
`timescale 1ns / 100ps
// Testbench for url_percent_escape_utf8: directed table and random UTF-8 strings, scoreboarded.
module tb_url_percent_escape_utf8;

    localparam int CYCLE_LIMIT  = 800000;
    localparam int RANDOM_ITEMS = 320;
    localparam int DRAIN_CYCLES = 16;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } esc_char_t;

    typedef struct packed {
        logic [7:0]  b;
        logic        last;
        logic [1:0]  n;
        logic [23:0] chars;
    } dir_row_t;

    logic       aclk;
    logic       aresetn;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;   // [7:0] in_byte
    logic       s_tlast;
    logic       m_tvalid;
    logic       m_tready;
    logic [7:0] m_tdata;   // [7:0] out_byte
    logic       m_tlast;

    logic [1:0]  row_typed_n;
    logic [23:0] row_typed_chars;

    logic [7:0] held [3];
    logic [1:0] held_n;
    logic [2:0] open_len;

    esc_char_t step_chars[$];
    esc_char_t pending_chars[$];
    dir_row_t  directed_rows[$];

    int error_count = 0;
    int cycle_count = 0;
    int items_sent  = 0;
    bit calm        = 1'b0;

    url_percent_escape_utf8 dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always #6 aclk = ~aclk;

    function automatic logic is_unreserved(input logic [7:0] b);
        return (b >= "0" && b <= "9") || (b >= "A" && b <= "Z") ||
               (b >= "a" && b <= "z") || b == "_" || b == "-" || b == ".";
    endfunction

    function automatic int lead_length(input logic [7:0] b);
        if (b[7:3] == 5'b11110) begin
            return 4;
        end else if (b[7:4] == 4'b1110) begin
            return 3;
        end else if (b[7:5] == 3'b110) begin
            return 2;
        end
        return 1;
    endfunction

    function automatic logic [7:0] nibble_char(input logic [3:0] nib);
        if (nib < 4'd10) begin
            return {4'h0, nib} + "0";
        end
        return {4'h0, nib} - 8'd10 + "A";
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    function void put_char(input logic [7:0] c);
        step_chars.push_back('{c, 1'b0});
    endfunction

    function void put_escaped_or_plain(input logic [7:0] b);
        if (is_unreserved(b)) begin
            put_char(b);
        end else begin
            put_char("%");
            put_char(nibble_char(b[7:4]));
            put_char(nibble_char(b[3:0]));
        end
    endfunction

    // Advance the escaper state by one byte and leave its characters in step_chars.
    function void escape_step(input logic [7:0] b, input logic last);
        logic [7:0] tail [4];
        int tail_n;
        int i;
        int k;
        int cl;
        step_chars.delete();
        if (open_len != 0 && int'(held_n) + 1 >= int'(open_len)) begin
            for (k = 0; k < int'(held_n); k++) put_char(held[k]);
            put_char(b);
            held_n = 0;
            open_len = 0;
        end else if (last) begin
            tail_n = 0;
            for (k = 0; k < int'(held_n); k++) begin
                tail[tail_n] = held[k];
                tail_n++;
            end
            tail[tail_n] = b;
            tail_n++;
            i = 0;
            while (i < tail_n) begin
                cl = lead_length(tail[i]);
                if (cl > 1 && i + cl <= tail_n) begin
                    for (k = 0; k < cl; k++) put_char(tail[i + k]);
                    i += cl;
                end else begin
                    put_escaped_or_plain(tail[i]);
                    i++;
                end
            end
            held_n = 0;
            open_len = 0;
        end else if (open_len != 0) begin
            held[held_n] = b;
            held_n = held_n + 2'd1;
        end else begin
            cl = lead_length(b);
            if (cl > 1) begin
                held[0] = b;
                held_n = 2'd1;
                open_len = 3'(cl);
            end else begin
                put_escaped_or_plain(b);
            end
        end
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH: %s", $realtime, msg);
        error_count++;
    endtask

    always @(posedge aclk) begin : scoreboard
        esc_char_t want;
        int k;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                escape_step(s_tdata, s_tlast);
                if (row_typed_n != 2'd0) begin
                    step_chars.delete();
                    for (k = 0; k < int'(row_typed_n); k++) put_char(row_typed_chars[8*k +: 8]);
                end
                if (s_tlast && step_chars.size() > 0) begin
                    step_chars[step_chars.size() - 1].last = 1'b1;
                end
                foreach (step_chars[j]) pending_chars.push_back(step_chars[j]);
            end
            if (m_tvalid && m_tready) begin
                if (pending_chars.size() == 0) begin
                    report_mismatch($sformatf("unexpected char 0x%02h last %0b",
                                              m_tdata, m_tlast));
                end else begin
                    want = pending_chars.pop_front();
                    if (m_tdata !== want.ch) begin
                        report_mismatch($sformatf("out_byte 0x%02h, want 0x%02h",
                                                  m_tdata, want.ch));
                    end
                    if (m_tlast !== want.last) begin
                        report_mismatch($sformatf("out_last %0b, want %0b on 0x%02h",
                                                  m_tlast, want.last, want.ch));
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("url_percent_escape_utf8 verification failed");
            $finish;
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic last,
                             input logic [1:0] typed_n, input logic [23:0] typed_chars);
        int gap;
        gap = calm ? 0 : pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid        <= 1'b1;
        s_tdata         <= b;
        s_tlast         <= last;
        row_typed_n     <= typed_n;
        row_typed_chars <= typed_chars;
        do @(posedge aclk); while (!s_tready);
        items_sent++;
    endtask

    task automatic wait_results_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_chars.size() != 0) @(posedge aclk);
    endtask

    task automatic send_random_string();
        logic [7:0] str [$];
        int units;
        int u;
        int kind;
        int len;
        int cut;
        int k;
        units = $urandom_range(1, 6);
        for (u = 0; u < units; u++) begin
            kind = $urandom_range(0, 9);
            if (kind <= 2) begin
                case ($urandom_range(0, 5))
                    0: str.push_back("0" + 8'($urandom_range(0, 9)));
                    1: str.push_back("A" + 8'($urandom_range(0, 25)));
                    2: str.push_back("a" + 8'($urandom_range(0, 25)));
                    3: str.push_back("_");
                    4: str.push_back("-");
                    default: str.push_back(".");
                endcase
            end else if (kind <= 4) begin
                str.push_back(8'($urandom_range(0, 255)));
            end else begin
                if (kind <= 6) begin
                    len = 2;
                end else if (kind == 7) begin
                    len = 3;
                end else if (kind == 8) begin
                    len = 4;
                end else begin
                    len = $urandom_range(2, 4);
                end
                case (len)
                    2: str.push_back({3'b110, 5'($urandom_range(0, 31))});
                    3: str.push_back({4'b1110, 4'($urandom_range(0, 15))});
                    default: str.push_back({5'b11110, 3'($urandom_range(0, 7))});
                endcase
                // truncated sequences end the string early
                cut = (kind == 9) ? $urandom_range(0, len - 2) : len - 1;
                for (k = 0; k < cut; k++) begin
                    if ($urandom_range(0, 7) == 0) begin
                        str.push_back(8'($urandom_range(0, 255)));
                    end else begin
                        str.push_back({2'b10, 6'($urandom_range(0, 63))});
                    end
                end
                if (kind == 9) break;
            end
        end
        foreach (str[i]) send_byte(str[i], i == str.size() - 1, 2'd0, 24'd0);
    endtask

    initial begin : result_sink
        int run;
        int gap;
        do @(posedge aclk); while (aresetn !== 1'b1);
        forever begin
            m_tready <= 1'b1;
            run = ($urandom_range(0, 99) < 80) ? $urandom_range(1, 6) : $urandom_range(40, 150);
            repeat (run) @(posedge aclk);
            gap = pick_gap();
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    end

    initial begin : stimulus
        int total;
        bit paused;
        aclk            = 1'b0;
        aresetn         = 1'b0;
        s_tvalid        = 1'b0;
        s_tdata         = 8'h00;
        s_tlast         = 1'b0;
        m_tready        = 1'b0;
        row_typed_n     = 2'd0;
        row_typed_chars = 24'd0;
        held[0]         = 8'h00;
        held[1]         = 8'h00;
        held[2]         = 8'h00;
        held_n          = 2'd0;
        open_len        = 3'd0;
        paused          = 1'b0;

        directed_rows.push_back('{"A",   1'b0, 2'd1, {16'h0, "A"}});
        directed_rows.push_back('{"0",   1'b0, 2'd1, {16'h0, "0"}});
        directed_rows.push_back('{"z",   1'b0, 2'd1, {16'h0, "z"}});
        directed_rows.push_back('{"_",   1'b0, 2'd1, {16'h0, "_"}});
        directed_rows.push_back('{"-",   1'b0, 2'd1, {16'h0, "-"}});
        directed_rows.push_back('{".",   1'b0, 2'd1, {16'h0, "."}});
        directed_rows.push_back('{8'h00, 1'b0, 2'd3, {"0", "0", "%"}});
        directed_rows.push_back('{8'h80, 1'b0, 2'd3, {"0", "8", "%"}});
        directed_rows.push_back('{8'hF8, 1'b0, 2'd3, {"8", "F", "%"}});
        directed_rows.push_back('{8'hFF, 1'b1, 2'd3, {"F", "F", "%"}});
        directed_rows.push_back('{8'hC3, 1'b0, 2'd0, 24'd0});
        directed_rows.push_back('{8'hA9, 1'b0, 2'd0, 24'd0});
        directed_rows.push_back('{8'hE2, 1'b0, 2'd0, 24'd0});
        directed_rows.push_back('{8'h82, 1'b0, 2'd0, 24'd0});
        directed_rows.push_back('{8'hAC, 1'b1, 2'd0, 24'd0});
        directed_rows.push_back('{8'hF0, 1'b0, 2'd0, 24'd0});
        directed_rows.push_back('{8'h9F, 1'b0, 2'd0, 24'd0});
        directed_rows.push_back('{8'h98, 1'b0, 2'd0, 24'd0});
        directed_rows.push_back('{8'h80, 1'b0, 2'd0, 24'd0});
        directed_rows.push_back('{8'hC3, 1'b0, 2'd0, 24'd0});
        directed_rows.push_back('{8'h41, 1'b0, 2'd0, 24'd0});
        directed_rows.push_back('{8'hE2, 1'b0, 2'd0, 24'd0});
        directed_rows.push_back('{8'hC3, 1'b1, 2'd0, 24'd0});
        directed_rows.push_back('{8'hF0, 1'b0, 2'd0, 24'd0});
        directed_rows.push_back('{8'hC3, 1'b0, 2'd0, 24'd0});
        directed_rows.push_back('{8'hA9, 1'b1, 2'd0, 24'd0});
        directed_rows.push_back('{8'hC0, 1'b1, 2'd3, {"0", "C", "%"}});

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[i]) begin
            send_byte(directed_rows[i].b, directed_rows[i].last,
                      directed_rows[i].n, directed_rows[i].chars);
        end
        wait_results_drained();

        total = directed_rows.size() + RANDOM_ITEMS;
        while (items_sent < total) begin
            calm = ($urandom_range(0, 4) == 0);
            send_random_string();
            if (!paused && items_sent >= directed_rows.size() + RANDOM_ITEMS / 2) begin
                wait_results_drained();
                paused = 1'b1;
            end
        end
        s_tvalid <= 1'b0;

        while (pending_chars.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (error_count == 0) begin
            $display("url_percent_escape_utf8 verification clean");
        end else begin
            $display("url_percent_escape_utf8 verification failed");
        end
        $finish;
    end

endmodule
